>>> rtl/core/bws_pkg.sv
// ----------------------------------------------------------------------------
// bws_pkg
// shared constants, field widths and register indexes of the bilinear
// wrap sampler
// ----------------------------------------------------------------------------
package bws_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int CFG_W    = 9;
	localparam int COORD_W  = 17;
	localparam int PIXEL_W  = 32;
	localparam int POS_W    = 8;
	localparam int S_DATA_W = 88;
	localparam int M_DATA_W = 32;

	// signed working width of integer coordinates and image sizes
	localparam int CW = 20;

	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 9'd256;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

endpackage

>>> rtl/core/bilinear_wrap_sampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_wrap_sampler_top
// rgba8 pixel store with bilinear sampling and edge wrap, one single-port
// synchronous memory read four times per covered sample
// ----------------------------------------------------------------------------
// a covered sample passes prepare, four reads through the single memory port
// and rounding before it enters the output register, an uncovered one goes
// from prepare straight to it; no new transaction is taken until the sequencer
// is back in idle, so writes go in at one per cycle only while no sample runs
// reset: arst_n clears control state and sets width and height to 256;
// the pixel store is not cleared and holds garbage until written
module bilinear_wrap_sampler_top #(
	parameter int MAX_WIDTH  = bws_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bws_pkg::MAX_HEIGHT_DEF,
	parameter int FRAC_BITS  = bws_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [bws_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// pixel_x, pixel_y, pixel_rgba, sample_u, sample_v, zero pad
	input  logic [bws_pkg::S_DATA_W-1:0] s_tdata,
	// command
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [bws_pkg::M_DATA_W-1:0] m_tdata,
	// covered
	output logic                         m_tuser
);

	localparam int CW    = bws_pkg::CW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int FW    = FRAC_BITS + 1;
	localparam int WT_W  = 2 * FRAC_BITS + 2;
	localparam int ACC_W = 2 * FRAC_BITS + 10;
	localparam logic [FW-1:0]  ONE_FIX = FW'(1) << FRAC_BITS;
	localparam logic [ACC_W:0] HALF    = (ACC_W + 1)'(1) << (2 * FRAC_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PREP  = 4'b0010,
		S_FETCH = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [bws_pkg::CFG_W-1:0] width_q;
	logic [bws_pkg::CFG_W-1:0] height_q;

	// input fields
	logic [bws_pkg::POS_W-1:0]           pixel_x;
	logic [bws_pkg::POS_W-1:0]           pixel_y;
	logic [bws_pkg::PIXEL_W-1:0]         pixel_rgba;
	logic signed [bws_pkg::COORD_W-1:0]  sample_u;
	logic signed [bws_pkg::COORD_W-1:0]  sample_v;

	assign pixel_x    = s_tdata[7:0];
	assign pixel_y    = s_tdata[15:8];
	assign pixel_rgba = s_tdata[47:16];
	assign sample_u   = s_tdata[64:48];
	assign sample_v   = s_tdata[81:65];

	logic s_fire;
	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid & s_tready;

	// latched sample coordinates
	logic signed [bws_pkg::COORD_W-1:0] u_q;
	logic signed [bws_pkg::COORD_W-1:0] v_q;

	// prepared sample
	logic [XW-1:0]   x1_q;
	logic [XW-1:0]   x2_q;
	logic [YW-1:0]   y1_q;
	logic [YW-1:0]   y2_q;
	logic [WT_W-1:0] w11_q;
	logic [WT_W-1:0] w21_q;
	logic [WT_W-1:0] w12_q;
	logic [WT_W-1:0] w22_q;
	logic            covered_q;
	logic [2:0]      cnt_q;
	logic [ACC_W-1:0] acc_q [4];

	// output register
	logic                         out_valid_q;
	logic [bws_pkg::M_DATA_W-1:0] out_data_q;
	logic                         out_covered_q;

	// effective image size
	logic signed [CW-1:0] w_raw;
	logic signed [CW-1:0] h_raw;
	logic signed [CW-1:0] w_eff;
	logic signed [CW-1:0] h_eff;

	assign w_raw = signed'(CW'(width_q));
	assign h_raw = signed'(CW'(height_q));

	always_comb begin
		w_eff = w_raw;
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (w_raw > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end
		h_eff = h_raw;
		if (height_q == '0) begin
			h_eff = CW'(1);
		end else if (h_raw > CW'(MAX_HEIGHT)) begin
			h_eff = CW'(MAX_HEIGHT);
		end
	end

	// neighbour coordinates with wrap
	logic [FRAC_BITS-1:0] fa;
	logic [FRAC_BITS-1:0] fb;
	logic signed [CW-1:0] x1;
	logic signed [CW-1:0] x2;
	logic signed [CW-1:0] y1;
	logic signed [CW-1:0] y2;
	logic signed [CW-1:0] x1w;
	logic signed [CW-1:0] x2w;
	logic signed [CW-1:0] y1w;
	logic signed [CW-1:0] y2w;
	logic                 covered;
	logic [FW-1:0]        wa;
	logic [FW-1:0]        wb;

	always_comb begin
		fa  = u_q[FRAC_BITS-1:0];
		fb  = v_q[FRAC_BITS-1:0];
		x1  = CW'(u_q >>> FRAC_BITS);
		y1  = CW'(v_q >>> FRAC_BITS);
		x2  = x1 + CW'(fa != '0);
		y2  = y1 + CW'(fb != '0);
		covered = !((x2 < 0) || (x1 >= w_eff) || (y2 < 0) || (y1 >= h_eff));
		x1w = (x1 < 0) ? x1 + w_eff : x1;
		y1w = (y1 < 0) ? y1 + h_eff : y1;
		x2w = (x2 >= w_eff) ? x2 - w_eff : x2;
		y2w = (y2 >= h_eff) ? y2 - h_eff : y2;
		wa  = ONE_FIX - FW'(fa);
		wb  = ONE_FIX - FW'(fb);
	end

	// memory port
	localparam int PIXEL_W_T = bws_pkg::PIXEL_W;
	logic [PIXEL_W_T-1:0] mem [DEPTH];
	logic [PIXEL_W_T-1:0] rd_data_q;
	logic                 mem_we;
	logic                 rd_en;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [XW-1:0]        rd_x;
	logic [YW-1:0]        rd_y;

	assign mem_we = s_fire && (s_tuser == bws_pkg::CMD_WRITE)
		&& (CW'(pixel_x) < CW'(MAX_WIDTH)) && (CW'(pixel_y) < CW'(MAX_HEIGHT));
	assign wr_addr = AW'(pixel_y) * AW'(MAX_WIDTH) + AW'(pixel_x);
	assign rd_en   = (state_q == S_FETCH) && (cnt_q != 3'd4);

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				rd_x = x1_q;
				rd_y = y1_q;
			end
			2'd1: begin
				rd_x = x2_q;
				rd_y = y1_q;
			end
			2'd2: begin
				rd_x = x1_q;
				rd_y = y2_q;
			end
			default: begin
				rd_x = x2_q;
				rd_y = y2_q;
			end
		endcase
	end

	assign rd_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= pixel_rgba;
		end else if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// weight of the pixel that arrives this cycle
	logic [WT_W-1:0] wsel;

	always_comb begin
		case (cnt_q)
			3'd1:    wsel = w11_q;
			3'd2:    wsel = w21_q;
			3'd3:    wsel = w12_q;
			3'd4:    wsel = w22_q;
			default: wsel = '0;
		endcase
	end

	logic [ACC_W-1:0] prod [4];
	logic [ACC_W:0]   rsum [4];
	logic [10:0]      rch  [4];
	logic [7:0]       chan [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod[k] = wsel * rd_data_q[8*k +: 8];
			rsum[k] = (ACC_W + 1)'(acc_q[k]) + HALF;
			rch[k]  = 11'(rsum[k] >> (2 * FRAC_BITS));
			chan[k] = (rch[k] > 11'd255) ? 8'd255 : rch[k][7:0];
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire && (s_tuser == bws_pkg::CMD_SAMPLE)) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= covered ? S_FETCH : S_DONE;
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sample datapath
	always_ff @(posedge clk) begin
		if (s_fire) begin
			u_q <= sample_u;
			v_q <= sample_v;
		end
		if (state_q == S_PREP) begin
			x1_q      <= x1w[XW-1:0];
			x2_q      <= x2w[XW-1:0];
			y1_q      <= y1w[YW-1:0];
			y2_q      <= y2w[YW-1:0];
			w11_q     <= wa * wb;
			w21_q     <= WT_W'(FW'(fa)) * WT_W'(wb);
			w12_q     <= WT_W'(wa) * WT_W'(FW'(fb));
			w22_q     <= WT_W'(fa) * WT_W'(fb);
			covered_q <= covered;
			for (int k = 0; k < 4; k++) begin
				acc_q[k] <= '0;
			end
		end else if ((state_q == S_FETCH) && (cnt_q != 3'd0)) begin
			for (int k = 0; k < 4; k++) begin
				acc_q[k] <= acc_q[k] + prod[k];
			end
		end
	end

	// configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= bws_pkg::IMAGE_WIDTH_RST;
			height_q    <= bws_pkg::IMAGE_HEIGHT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bws_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					bws_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_data_q    <= {chan[3], chan[2], chan[1], chan[0]};
			out_covered_q <= covered_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_covered_q;

endmodule

>>> test/bilinear_wrap_sampler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_wrap_sampler_top_tb
// drives pixel writes and bilinear samples into the sampler under several
// image sizes, predicts every sample from a local copy of the pixel store and
// checks each result field by field, with random bursts, receiver stalls and
// one long hold-off that fills the pipeline
// ----------------------------------------------------------------------------
module bilinear_wrap_sampler_top_tb;

	localparam int CFG_W    = bws_pkg::CFG_W;
	localparam int COORD_W  = bws_pkg::COORD_W;
	localparam int PIXEL_W  = bws_pkg::PIXEL_W;
	localparam int POS_W    = bws_pkg::POS_W;
	localparam int S_DATA_W = bws_pkg::S_DATA_W;
	localparam int M_DATA_W = bws_pkg::M_DATA_W;

	localparam int CLK_PERIOD   = 12;
	localparam int IMG_W        = bws_pkg::MAX_WIDTH_DEF;
	localparam int IMG_H        = bws_pkg::MAX_HEIGHT_DEF;
	localparam int FB           = bws_pkg::FRAC_BITS_DEF;
	localparam int ONE_FIX      = 1 << FB;
	localparam int ROUND_HALF   = 1 << (2 * FB - 1);
	localparam int SETTLE       = 16;
	localparam int LONG_HOLD    = 400;
	localparam int STALL_LIMIT  = 5000;

	typedef enum int {
		RX_ALWAYS,
		RX_MOSTLY,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	typedef struct {
		bws_pkg::command_t         cmd;
		logic [POS_W-1:0]          px;
		logic [POS_W-1:0]          py;
		logic [PIXEL_W-1:0]        rgba;
		logic signed [COORD_W-1:0] su;
		logic signed [COORD_W-1:0] sv;
	} pix_req_t;

	typedef struct packed {
		logic                covered;
		logic [M_DATA_W-1:0] rgba;
	} texel_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	// pixel_x, pixel_y, pixel_rgba, sample_u, sample_v, zero pad
	logic [S_DATA_W-1:0] s_tdata;
	// command
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// out_red, out_green, out_blue, out_alpha
	logic [M_DATA_W-1:0] m_tdata;
	// covered
	logic                m_tuser;

	logic [PIXEL_W-1:0] pix_mem [0:IMG_W*IMG_H-1];
	bit                 pix_known [0:IMG_W*IMG_H-1];
	logic [CFG_W-1:0]   img_w;
	logic [CFG_W-1:0]   img_h;
	texel_t             texel_q [$];
	int                 errors = 0;
	int                 idle_cycles = 0;
	int                 burst_left;
	bit                 sender_gaps;
	int                 hold_reqs = 0;
	string              chan_name [4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

	bilinear_wrap_sampler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int eff_size(input logic [CFG_W-1:0] r, input int lim);
		if (r == 0) return 1;
		if (r > lim) return lim;
		return int'(r);
	endfunction

	// floor and ceiling neighbours after edge wrap, 0 when the area misses the image
	function automatic bit locate(input logic signed [COORD_W-1:0] su,
			input logic signed [COORD_W-1:0] sv, output int x1, output int x2,
			output int y1, output int y2);
		int w;
		int h;
		int u;
		int v;
		w = eff_size(img_w, IMG_W);
		h = eff_size(img_h, IMG_H);
		u = int'(su);
		v = int'(sv);
		x1 = u >>> FB;
		y1 = v >>> FB;
		x2 = x1 + ((su[FB-1:0] != 0) ? 1 : 0);
		y2 = y1 + ((sv[FB-1:0] != 0) ? 1 : 0);
		if (x2 < 0 || x1 > w - 1 || y2 < 0 || y1 > h - 1) return 1'b0;
		if (x1 < 0) x1 += w;
		if (y1 < 0) y1 += h;
		if (x2 >= w) x2 -= w;
		if (y2 >= h) y2 -= h;
		return 1'b1;
	endfunction

	function automatic texel_t blend_texel(input pix_req_t req);
		texel_t t;
		int x1;
		int x2;
		int y1;
		int y2;
		int fa;
		int fb;
		int w11;
		int w21;
		int w12;
		int w22;
		int sum;
		logic [PIXEL_W-1:0] p11;
		logic [PIXEL_W-1:0] p12;
		logic [PIXEL_W-1:0] p21;
		logic [PIXEL_W-1:0] p22;
		t = '0;
		if (!locate(req.su, req.sv, x1, x2, y1, y2)) return t;
		p11 = pix_mem[y1 * IMG_W + x1];
		p12 = pix_mem[y2 * IMG_W + x1];
		p21 = pix_mem[y1 * IMG_W + x2];
		p22 = pix_mem[y2 * IMG_W + x2];
		fa = int'(req.su[FB-1:0]);
		fb = int'(req.sv[FB-1:0]);
		w11 = (ONE_FIX - fa) * (ONE_FIX - fb);
		w21 = fa * (ONE_FIX - fb);
		w12 = (ONE_FIX - fa) * fb;
		w22 = fa * fb;
		for (int k = 0; k < 4; k++) begin
			sum = w11 * int'(p11[8*k +: 8]) + w21 * int'(p21[8*k +: 8])
				+ w12 * int'(p12[8*k +: 8]) + w22 * int'(p22[8*k +: 8]);
			sum = (sum + ROUND_HALF) >> (2 * FB);
			if (sum > 255) sum = 255;
			t.rgba[8*k +: 8] = sum[7:0];
		end
		t.covered = 1'b1;
		return t;
	endfunction

	function automatic pix_req_t noise_req(input bws_pkg::command_t cmd);
		pix_req_t req;
		req.cmd  = cmd;
		req.px   = POS_W'($urandom);
		req.py   = POS_W'($urandom);
		req.rgba = $urandom;
		req.su   = COORD_W'($urandom);
		req.sv   = COORD_W'($urandom);
		return req;
	endfunction

	task automatic send_item(input pix_req_t req);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= req.cmd;
		s_tdata  <= S_DATA_W'({req.sv, req.su, req.rgba, req.py, req.px});
		do @(posedge clk); while (!s_tready);
		if (req.cmd == bws_pkg::CMD_WRITE) begin
			pix_mem[int'(req.py) * IMG_W + int'(req.px)] = req.rgba;
			pix_known[int'(req.py) * IMG_W + int'(req.px)] = 1'b1;
		end else begin
			texel_q.push_back(blend_texel(req));
		end
	endtask

	task automatic stop_sender();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drain();
		stop_sender();
		while (texel_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_write(input int x, input int y, input logic [PIXEL_W-1:0] rgba);
		pix_req_t req;
		req = noise_req(bws_pkg::CMD_WRITE);
		req.px = x[POS_W-1:0];
		req.py = y[POS_W-1:0];
		req.rgba = rgba;
		send_item(req);
	endtask

	task automatic fill_pixel(input int x, input int y);
		if (!pix_known[y * IMG_W + x]) send_write(x, y, $urandom);
	endtask

	// writes any neighbour not yet stored, then samples
	task automatic send_sample(input int u, input int v);
		pix_req_t req;
		int x1;
		int x2;
		int y1;
		int y2;
		req = noise_req(bws_pkg::CMD_SAMPLE);
		req.su = u[COORD_W-1:0];
		req.sv = v[COORD_W-1:0];
		if (locate(req.su, req.sv, x1, x2, y1, y2)) begin
			fill_pixel(x1, y1);
			fill_pixel(x1, y2);
			fill_pixel(x2, y1);
			fill_pixel(x2, y2);
		end
		send_item(req);
	endtask

	task automatic cfg_write(input bws_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] val);
		wait_drain();
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bws_pkg::REG_IMAGE_WIDTH) img_w = val;
		else img_h = val;
	endtask

	task automatic set_size(input int w, input int h);
		cfg_write(bws_pkg::REG_IMAGE_WIDTH, w[CFG_W-1:0]);
		cfg_write(bws_pkg::REG_IMAGE_HEIGHT, h[CFG_W-1:0]);
	endtask

	function automatic int near_coord(input int span);
		int c;
		c = $urandom_range(0, span * ONE_FIX + ONE_FIX) - ONE_FIX;
		if ($urandom_range(0, 4) == 0) c = c & ~(ONE_FIX - 1);
		if (c > 65535) c = 65535;
		return c;
	endfunction

	task automatic random_op();
		int r;
		int w;
		int h;
		r = $urandom_range(0, 99);
		w = eff_size(img_w, IMG_W);
		h = eff_size(img_h, IMG_H);
		if (r < 55)
			send_sample(near_coord(w), near_coord(h));
		else if (r < 65)
			send_sample($urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536);
		else if (r < 90)
			send_write($urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
		else
			send_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
	endtask

	task automatic test_directed();
		sender_gaps = 1'b0;
		// reset size, rounding half up between a zero and a one pixel
		send_write(0, 0, 32'h0000_0000);
		send_write(1, 0, 32'h0101_0101);
		send_sample(128, 0);
		send_write(255, 255, 32'hFFFF_FFFF);
		send_write(0, 255, 32'hFFFF_FFFF);
		send_write(255, 0, 32'h00FF_00FF);
		send_sample(-255, -255);
		send_sample(65535, 65535);
		send_sample(255 * ONE_FIX, 255 * ONE_FIX);
		send_sample(-256, 0);
		send_sample(0, -256);
		send_sample(-65536, 65535);
		// single pixel image, wrap on both sides
		set_size(1, 1);
		send_sample(0, 0);
		send_sample(-128, -128);
		send_sample(128, 128);
		send_sample(ONE_FIX, 0);
		// zero and oversized registers
		set_size(0, 511);
		send_sample(0, 0);
		send_sample(100, 65535);
		send_sample(0, 256 * ONE_FIX);
		wait_drain();
	endtask

	task automatic test_random_sizes();
		int sz_w [10] = '{2, 3, 256, 1, 256, 17, 0, 511, 0, 0};
		int sz_h [10] = '{2, 5, 256, 256, 1, 9, 0, 300, 0, 0};
		sz_w[8] = $urandom_range(1, 256);
		sz_h[8] = $urandom_range(1, 256);
		sz_w[9] = $urandom_range(0, 511);
		sz_h[9] = $urandom_range(0, 511);
		for (int s = 0; s < 10; s++) begin
			set_size(sz_w[s], sz_h[s]);
			sender_gaps = (s % 3 != 1);
			repeat (55) random_op();
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		set_size(8, 8);
		sender_gaps = 1'b0;
		hold_reqs++;
		repeat (50) send_sample(near_coord(8), near_coord(8));
		// let everything out before going on
		wait_drain();
		sender_gaps = 1'b1;
		repeat (40) random_op();
		wait_drain();
	endtask

	// receiver stalls
	initial begin
		rx_mode_t mode;
		int       left;
		int       phase;
		int       holds_done;
		m_tready = 1'b0;
		mode = RX_ALWAYS;
		left = 0;
		phase = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done = hold_reqs;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				left = $urandom_range(20, 200);
			end
			left--;
			phase++;
			case (mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
				RX_PATTERN: m_tready <= (phase % 5 < 2);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result check
	always @(posedge clk) begin
		texel_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (texel_q.size() == 0) begin
				$error("result with nothing expected: covered %0d data %h", m_tuser, m_tdata);
				errors++;
			end else begin
				want = texel_q.pop_front();
				if (m_tuser !== want.covered) begin
					$error("covered: expected %0d, got %0d", want.covered, m_tuser);
					errors++;
				end
				for (int k = 0; k < 4; k++) begin
					if (m_tdata[8*k +: 8] !== want.rgba[8*k +: 8]) begin
						$error("%s: expected %0d, got %0d", chan_name[k],
							want.rgba[8*k +: 8], m_tdata[8*k +: 8]);
						errors++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		img_w       = bws_pkg::IMAGE_WIDTH_RST;
		img_h       = bws_pkg::IMAGE_HEIGHT_RST;
		burst_left  = 0;
		sender_gaps = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_sizes();
		test_backpressure();
		wait_drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
